@@ rtl/core/itoa_pkg.sv @@
// types and constants shared by the integer to ascii converter
// no dependencies
package itoa_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DIGITS  = 10;
    localparam int unsigned BCD_W   = 4 * DIGITS;
    localparam int unsigned CNT_W   = $clog2(VALUE_W);
    localparam int unsigned LEFT_W  = $clog2(DIGITS + 1);

    localparam logic [CNT_W-1:0]  SHIFT_LAST = CNT_W'(VALUE_W - 1);
    localparam logic [LEFT_W-1:0] LEFT_FULL  = LEFT_W'(DIGITS);
    localparam logic [LEFT_W-1:0] LEFT_ONE   = LEFT_W'(1);

    localparam logic [1:0] REQ_SDEC = 2'd0;
    localparam logic [1:0] REQ_UDEC = 2'd1;
    localparam logic [1:0] REQ_HEX  = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_out_word;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [BCD_W-1:0] digits;
    } t_conv_res;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_RUN,
        CV_HOLD
    } t_conv_state;

    typedef enum logic {
        EM_IDLE,
        EM_RUN
    } t_emit_state;

endpackage

@@ rtl/core/itoa_bcd.sv @@
// bit-serial binary to bcd converter (shift and add three), hex passes straight through
// depends on itoa_pkg
module itoa_bcd (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_hex,
    input  logic                        i_neg,
    input  logic [itoa_pkg::VALUE_W-1:0] i_mag,
    input  logic                        i_take,
    output logic                        o_idle,
    output itoa_pkg::t_conv_res         o_res
);

    itoa_pkg::t_conv_state          r_state, n_state;
    logic [itoa_pkg::BCD_W-1:0]     r_bcd, n_bcd;
    logic [itoa_pkg::BCD_W-1:0]     adj;
    logic [itoa_pkg::VALUE_W-1:0]   r_bin, n_bin;
    logic [itoa_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                           r_neg, n_neg;

    always_comb begin
        for (int k = 0; k < itoa_pkg::DIGITS; k++) begin
            adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                      : r_bcd[4*k +: 4];
        end
    end

    always_comb begin
        n_state = r_state;
        n_bcd   = r_bcd;
        n_bin   = r_bin;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        case (r_state)
            itoa_pkg::CV_IDLE: begin
                if (i_start) begin
                    n_neg = i_neg;
                    if (i_hex) begin
                        n_bcd   = {{(itoa_pkg::BCD_W - itoa_pkg::VALUE_W){1'b0}}, i_mag};
                        n_state = itoa_pkg::CV_HOLD;
                    end else begin
                        n_bcd   = '0;
                        n_bin   = i_mag;
                        n_cnt   = '0;
                        n_state = itoa_pkg::CV_RUN;
                    end
                end
            end
            itoa_pkg::CV_RUN: begin
                n_bcd = {adj[itoa_pkg::BCD_W-2:0], r_bin[itoa_pkg::VALUE_W-1]};
                n_bin = {r_bin[itoa_pkg::VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == itoa_pkg::SHIFT_LAST) begin
                    n_state = itoa_pkg::CV_HOLD;
                end
            end
            itoa_pkg::CV_HOLD: begin
                if (i_take) begin
                    n_state = itoa_pkg::CV_IDLE;
                end
            end
            default: begin
                n_state = itoa_pkg::CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itoa_pkg::CV_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bcd <= n_bcd;
        r_bin <= n_bin;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
    end

    assign o_idle       = (r_state == itoa_pkg::CV_IDLE);
    assign o_res.valid  = (r_state == itoa_pkg::CV_HOLD);
    assign o_res.neg    = r_neg;
    assign o_res.digits = r_bcd;

endmodule

@@ rtl/core/itoa_emit.sv @@
// character emitter: skips leading zero digits, sends sign and digits one word per cycle
// while the output is not stalled; depends on itoa_pkg
module itoa_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itoa_pkg::t_conv_res i_res,
    output logic                o_take,
    output logic                o_valid,
    input  logic                i_stall,
    output itoa_pkg::t_out_word o_word
);

    itoa_pkg::t_emit_state          r_state, n_state;
    logic [itoa_pkg::BCD_W-1:0]     r_digits, n_digits;
    logic [itoa_pkg::LEFT_W-1:0]    r_left, n_left;
    logic                           r_neg, n_neg;
    logic                           r_started, n_started;
    logic                           r_valid, n_valid;
    itoa_pkg::t_out_word            r_word, n_word;
    logic [3:0]                     top_nib;
    logic [7:0]                     ch;
    logic                           slot;

    assign top_nib = r_digits[itoa_pkg::BCD_W-1 -: 4];
    assign ch      = (top_nib < 4'd10) ? itoa_pkg::CH_ZERO + {4'h0, top_nib}
                                       : itoa_pkg::CH_A + {4'h0, top_nib} - 8'd10;
    assign slot    = !r_valid || !i_stall;

    always_comb begin
        n_state   = r_state;
        n_digits  = r_digits;
        n_left    = r_left;
        n_neg     = r_neg;
        n_started = r_started;
        n_valid   = r_valid && i_stall;
        n_word    = r_word;
        o_take    = 1'b0;
        case (r_state)
            itoa_pkg::EM_IDLE: begin
                if (i_res.valid) begin
                    o_take    = 1'b1;
                    n_digits  = i_res.digits;
                    n_neg     = i_res.neg;
                    n_left    = itoa_pkg::LEFT_FULL;
                    n_started = 1'b0;
                    n_state   = itoa_pkg::EM_RUN;
                end
            end
            itoa_pkg::EM_RUN: begin
                if (!r_started && r_left != itoa_pkg::LEFT_ONE && top_nib == 4'h0) begin
                    // leading zero digit
                    n_digits = {r_digits[itoa_pkg::BCD_W-5:0], 4'h0};
                    n_left   = r_left - 1'b1;
                end else if (slot) begin
                    n_valid = 1'b1;
                    if (r_neg) begin
                        n_word.char_code = itoa_pkg::CH_MINUS;
                        n_word.last_char = 1'b0;
                        n_neg            = 1'b0;
                    end else begin
                        n_word.char_code = ch;
                        n_word.last_char = (r_left == itoa_pkg::LEFT_ONE);
                        n_started        = 1'b1;
                        n_digits         = {r_digits[itoa_pkg::BCD_W-5:0], 4'h0};
                        n_left           = r_left - 1'b1;
                        if (r_left == itoa_pkg::LEFT_ONE) begin
                            n_state = itoa_pkg::EM_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = itoa_pkg::EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itoa_pkg::EM_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_digits  <= n_digits;
        r_left    <= n_left;
        r_neg     <= n_neg;
        r_started <= n_started;
        r_word    <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

@@ rtl/core/int_to_ascii_converter_unit.sv @@
// integer to ascii converter top level: mode decode, bcd converter and character emitter
// depends on itoa_pkg, itoa_bcd, itoa_emit
// a new word is accepted only while the converter is idle; it stays busy for the 32-step
// shift and add on a decimal word and until the emitter takes the result, so one word can
// be converting while the emitter still sends the characters of the word ahead of it
// reset: synchronous active-low, clears the converter and emitter state and output valid
module int_to_ascii_converter_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  itoa_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output itoa_pkg::t_out_word o_word
);

    logic                           start;
    logic                           is_neg;
    logic                           is_hex;
    logic [itoa_pkg::VALUE_W-1:0]   mag;
    logic                           conv_idle;
    logic                           take;
    itoa_pkg::t_conv_res            conv_res;

    assign start  = i_valid && !o_stall;
    assign is_neg = (i_word.req_type == itoa_pkg::REQ_SDEC) && i_word.value[itoa_pkg::VALUE_W-1];
    assign is_hex = (i_word.req_type == itoa_pkg::REQ_HEX);
    assign mag    = is_neg ? (~i_word.value + 1'b1) : i_word.value;
    assign o_stall = !conv_idle;

    itoa_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_hex   (is_hex),
        .i_neg   (is_neg),
        .i_mag   (mag),
        .i_take  (take),
        .o_idle  (conv_idle),
        .o_res   (conv_res)
    );

    itoa_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (conv_res),
        .o_take  (take),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    a_take_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> conv_res.valid)
        else $error("emitter took a result the converter did not hold");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("converter not busy after accepting a word");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_word.char_code == itoa_pkg::CH_MINUS && o_word.last_char))
        else $error("minus sign flagged as last character");

endmodule

@@ sim/int_to_ascii_converter_unit_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for int_to_ascii_converter_unit: directed and random conversions
// checked character by character against a behavioural formatter; depends on itoa_pkg
module int_to_ascii_converter_unit_tb;

    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int N_RANDOM   = 241;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN      = 60;
    localparam int SEND_IDLE [3] = '{33, 84, 0};
    localparam int RECV_IDLE [3] = '{84, 33, 0};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    itoa_pkg::t_in_word  i_word;
    logic                o_valid;
    logic                i_stall;
    itoa_pkg::t_out_word o_word;

    itoa_pkg::t_in_word  word_q [$];
    int                  phase_q [$];
    itoa_pkg::t_out_word char_q [$];
    itoa_pkg::t_out_word want;
    int                  rx_phase;
    int                  errors;
    int                  idle_cycles;

    int_to_ascii_converter_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_word (i_word),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_word (o_word)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void format_chars(input itoa_pkg::t_in_word w);
        logic [31:0] mag;
        logic [31:0] radix;
        logic [3:0]  rem;
        logic        neg;
        logic [7:0]  digs [$];
        mag   = w.value;
        radix = 32'd10;
        neg   = 1'b0;
        if (w.req_type == itoa_pkg::REQ_SDEC && w.value[31]) begin
            neg = 1'b1;
            mag = 32'd0 - w.value;
        end else if (w.req_type == itoa_pkg::REQ_HEX) begin
            radix = 32'd16;
        end
        do begin
            rem = 4'(mag % radix);
            digs.push_front(rem < 4'd10 ? itoa_pkg::CH_ZERO + 8'(rem)
                                        : itoa_pkg::CH_A + 8'(rem) - 8'd10);
            mag = mag / radix;
        end while (mag != 0 && digs.size() < itoa_pkg::DIGITS);
        if (neg)
            char_q.push_back(itoa_pkg::t_out_word'{char_code: itoa_pkg::CH_MINUS,
                                                   last_char: 1'b0});
        foreach (digs[k])
            char_q.push_back(itoa_pkg::t_out_word'{char_code: digs[k],
                                                   last_char: k == digs.size() - 1});
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(3))
            0: random_value = $urandom();
            1: random_value = $urandom() >> $urandom_range(31);
            2: random_value = 32'd0 - ($urandom() >> $urandom_range(31));
            default: random_value = 32'(10 ** $urandom_range(9)) - 32'($urandom_range(1));
        endcase
    endfunction

    task automatic add_word(input logic [1:0] req, input logic [31:0] val, input int ph);
        word_q.push_back(itoa_pkg::t_in_word'{req_type: req, value: val});
        phase_q.push_back(ph);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                format_chars(i_word);
                void'(word_q.pop_front());
                rx_phase = phase_q.pop_front();
            end
            if (!(i_valid && o_stall)) begin
                if (word_q.size() > 0 && $urandom_range(99) >= SEND_IDLE[phase_q[0]]) begin
                    i_valid <= 1'b1;
                    i_word  <= word_q[0];
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (char_q.size() == 0) begin
                    $error("unexpected word: char_code %h last_char %b",
                           o_word.char_code, o_word.last_char);
                    errors++;
                end else begin
                    want = char_q.pop_front();
                    if (o_word.char_code !== want.char_code) begin
                        $error("char_code: expected %h, got %h", want.char_code, o_word.char_code);
                        errors++;
                    end
                    if (o_word.last_char !== want.last_char) begin
                        $error("last_char: expected %b, got %b", want.last_char, o_word.last_char);
                        errors++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < RECV_IDLE[rx_phase]);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_word      = '0;
        i_stall     = 1'b0;
        rx_phase    = 0;
        errors      = 0;
        idle_cycles = 0;

        // extremes, every mode and the unused mode
        add_word(itoa_pkg::REQ_SDEC, 32'h0000_0000, 0);
        add_word(itoa_pkg::REQ_SDEC, 32'h8000_0000, 0);
        add_word(itoa_pkg::REQ_SDEC, 32'h7fff_ffff, 0);
        add_word(itoa_pkg::REQ_SDEC, 32'hffff_ffff, 0);
        add_word(itoa_pkg::REQ_SDEC, 32'h0000_0001, 0);
        add_word(itoa_pkg::REQ_SDEC, 32'hffff_fff6, 0);
        add_word(itoa_pkg::REQ_UDEC, 32'h0000_0000, 0);
        add_word(itoa_pkg::REQ_UDEC, 32'hffff_ffff, 0);
        add_word(itoa_pkg::REQ_UDEC, 32'd1000000000, 0);
        add_word(itoa_pkg::REQ_UDEC, 32'd999999999, 0);
        add_word(itoa_pkg::REQ_UDEC, 32'h8000_0000, 0);
        add_word(itoa_pkg::REQ_HEX, 32'h0000_0000, 0);
        add_word(itoa_pkg::REQ_HEX, 32'hffff_ffff, 0);
        add_word(itoa_pkg::REQ_HEX, 32'hdead_beef, 0);
        add_word(itoa_pkg::REQ_HEX, 32'h0000_000a, 0);
        add_word(itoa_pkg::REQ_HEX, 32'h1234_5678, 0);
        add_word(REQ_SPARE, 32'h0000_0000, 0);
        add_word(REQ_SPARE, 32'hffff_ffff, 0);
        add_word(REQ_SPARE, 32'd42, 0);

        for (int n = 0; n < N_RANDOM; n++)
            add_word($urandom_range(9) == 0 ? REQ_SPARE : 2'($urandom_range(2)),
                     random_value(), n * 3 / N_RANDOM);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_q.size() > 0 || char_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (errors == 0 && char_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/itoa_pkg.sv
rtl/core/itoa_bcd.sv
rtl/core/itoa_emit.sv
rtl/core/int_to_ascii_converter_unit.sv
sim/int_to_ascii_converter_unit_tb.sv
